/* sv/qvf_pkg.sv */
package qvf_pkg;

	// limits and widths
	localparam int MAX_TRACKS = 4096;
	localparam int ANGLE_BITS = 16;
	localparam logic [12:0] MAX_CNT = 13'(MAX_TRACKS);

	// quarter-sine polynomial, Q30
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [30:0] COEF1 = 31'd1686629713;
	localparam logic [30:0] COEF3 = 31'd693598668;
	localparam logic [30:0] COEF5 = 31'd85569306;
	localparam logic [30:0] COEF7 = 31'd5026995;
	localparam logic [30:0] COEF9 = 31'd172272;

	// event status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NEG  = 2'd1,
		ST_FEW  = 2'd2,
		ST_MANY = 2'd3
	} status_t;

	// closed event handed from front to back
	typedef struct packed {
		logic signed [28:0] cos_sum;
		logic signed [28:0] sin_sum;
		logic [12:0]        m;
		status_t            cls;
		logic               run_end;
	} event_rec_t;

	// coefficient used at the horner steps after the first two
	function automatic logic [30:0] horner_coef(input logic [2:0] k);
		logic [30:0] c;
		case (k)
			3'd2:    c = COEF7;
			3'd3:    c = COEF5;
			3'd4:    c = COEF3;
			default: c = COEF1;
		endcase
		return c;
	endfunction

endpackage

/* sv/q_vector_two_particle_flow_unit.sv */
// input beat: a beat with a track runs seven passes of the two-lane sine/cosine
// horner multiplier; an event end then goes through a push state to queue the event
// back end per event: squares, 18-step divider, 15-step root; a negative correlation
// skips the root, a flagged event skips all three, and at run end the divider forms
// the average; arst_n clears sums, counters, queue and output valid
module q_vector_two_particle_flow_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // phi
	input  logic [1:0]  s_axis_tuser,  // has_track, end_of_event
	input  logic        s_axis_tlast,  // end_of_run
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // event_number, track_total, correlation,
	                                   // flow_v2, status, run_average, zero pad
	output logic        m_axis_tuser   // average_valid
);
	import qvf_pkg::*;

	event_rec_t push_rec, pop_rec;
	logic       push, q_full, q_pop, q_empty;
	logic [15:0] event_number, correlation;
	logic [12:0] track_total;
	logic [14:0] flow_v2, run_average;
	logic [1:0]  status;

	// track accumulation front end
	qvf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.phi          (s_axis_tdata),
		.has_track    (s_axis_tuser[0]),
		.end_of_event (s_axis_tuser[1]),
		.end_of_run   (s_axis_tlast),
		.push         (push),
		.rec          (push_rec),
		.q_full       (q_full)
	);

	// closed events waiting for the back end
	qvf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (push_rec),
		.full   (q_full),
		.pop    (q_pop),
		.rd_rec (pop_rec),
		.empty  (q_empty)
	);

	// correlation, root and run average
	qvf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.rec_in        (pop_rec),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.event_number  (event_number),
		.track_total   (track_total),
		.correlation   (correlation),
		.flow_v2       (flow_v2),
		.status        (status),
		.run_average   (run_average),
		.average_valid (m_axis_tuser)
	);

	// result beat packing
	assign m_axis_tdata = {3'b0, run_average, status, flow_v2, correlation,
	                       track_total, event_number};

	// checks
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("event pushed into full queue");

	a_avg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[76:62] == 15'd0))
		else $error("run average set outside run end");

	a_v2_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[61:60] != ST_OK) |-> (m_axis_tdata[59:45] == 15'd0))
		else $error("flow value set on flagged event");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("pop from empty queue");

endmodule

/* sv/qvf_front.sv */
module qvf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         phi,
	input  logic                has_track,
	input  logic                end_of_event,
	input  logic                end_of_run,
	output logic                push,
	output qvf_pkg::event_rec_t rec,
	input  logic                q_full
);
	import qvf_pkg::*;

	localparam int FRAC_W = ANGLE_BITS - 2;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CALC = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic [2:0]         k_q;
	logic [1:0]         quad_q;
	logic [30:0]        tt_q [2];
	logic [30:0]        t2_q [2];
	logic [61:0]        prod_q [2];
	logic signed [28:0] cos_q, sin_q;
	logic [12:0]        cnt_q;
	logic               ev_end_q, run_end_q;

	logic [ANGLE_BITS-1:0] ang;
	logic [FRAC_W-1:0]     frac;
	logic [30:0]           t_in;
	logic [31:0]           shr [2];
	logic [30:0]           ma [2], mb [2];
	logic [61:0]           mul [2];
	logic [32:0]           rnd [2];
	logic [14:0]           sine [2];
	logic signed [28:0]    u_s, w_s, c_s, s_s;
	logic                  need_calc;

	// doubled angle split into quadrant and Q30 fraction
	assign ang  = {phi[ANGLE_BITS-2:0], 1'b0};
	assign frac = ang[FRAC_W-1:0];
	assign t_in = {1'b0, frac, {(32 - ANGLE_BITS){1'b0}}};
	assign need_calc = has_track && (cnt_q < MAX_CNT);

	// two horner lanes: sin(t) and sin(1-t)
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			shr[l] = prod_q[l][61:30];
			priority if (k_q == 3'd0) begin
				ma[l] = tt_q[l];
				mb[l] = tt_q[l];
			end else if (k_q == 3'd1) begin
				ma[l] = shr[l][30:0];
				mb[l] = COEF9;
			end else begin
				ma[l] = (k_q == 3'd5) ? tt_q[l] : t2_q[l];
				mb[l] = horner_coef(k_q) - shr[l][30:0];
			end
			mul[l]  = ma[l] * mb[l];
			rnd[l]  = {1'b0, shr[l]} + 33'd16384;
			sine[l] = (rnd[l][32:15] > 18'd32767) ? 15'h7fff : rnd[l][29:15];
		end
	end

	// quadrant symmetry
	always_comb begin
		u_s = signed'({14'b0, sine[0]});
		w_s = signed'({14'b0, sine[1]});
		unique case (quad_q)
			2'd0: begin c_s = w_s;  s_s = u_s;  end
			2'd1: begin c_s = -u_s; s_s = w_s;  end
			2'd2: begin c_s = -w_s; s_s = -u_s; end
			default: begin c_s = u_s; s_s = -w_s; end
		endcase
	end

	// event record and handshake
	assign in_ready    = (state_q == F_IDLE);
	assign push        = (state_q == F_PUSH) && !q_full;
	assign rec.cos_sum = cos_q;
	assign rec.sin_sum = sin_q;
	assign rec.m       = cnt_q;
	assign rec.run_end = run_end_q;
	assign rec.cls     = (cnt_q > MAX_CNT) ? ST_MANY :
	                     (cnt_q < 13'd2)   ? ST_FEW  : ST_OK;

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid && need_calc) begin
			tt_q[0] <= t_in;
			tt_q[1] <= ONE_Q30 - t_in;
			quad_q  <= ang[ANGLE_BITS-1:ANGLE_BITS-2];
		end
		if (state_q == F_CALC) begin
			for (int l = 0; l < 2; l++) begin
				prod_q[l] <= mul[l];
				if (k_q == 3'd1) t2_q[l] <= shr[l][30:0];
			end
		end
	end

	// control and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			k_q       <= 3'd0;
			cos_q     <= '0;
			sin_q     <= '0;
			cnt_q     <= '0;
			ev_end_q  <= 1'b0;
			run_end_q <= 1'b0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						ev_end_q  <= end_of_event || end_of_run;
						run_end_q <= end_of_run;
						k_q       <= 3'd0;
						if (has_track && cnt_q <= MAX_CNT) cnt_q <= cnt_q + 13'd1;
						if (need_calc) state_q <= F_CALC;
						else if (end_of_event || end_of_run) state_q <= F_PUSH;
					end
				end
				F_CALC: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd6) begin
						cos_q   <= cos_q + c_s;
						sin_q   <= sin_q + s_s;
						state_q <= ev_end_q ? F_PUSH : F_IDLE;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						cos_q   <= '0;
						sin_q   <= '0;
						cnt_q   <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

/* sv/qvf_queue.sv */
module qvf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  qvf_pkg::event_rec_t wr_rec,
	output logic                full,
	input  logic                pop,
	output qvf_pkg::event_rec_t rd_rec,
	output logic                empty
);
	import qvf_pkg::*;

	event_rec_t slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign full   = (fill_q == 2'd2);
	assign empty  = (fill_q == 2'd0);
	assign rd_rec = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_rec;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

endmodule

/* sv/qvf_back.sv */
module qvf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	output logic                q_pop,
	input  qvf_pkg::event_rec_t rec_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         event_number,
	output logic [12:0]         track_total,
	output logic [15:0]         correlation,
	output logic [14:0]         flow_v2,
	output logic [1:0]          status,
	output logic [14:0]         run_average,
	output logic                average_valid
);
	import qvf_pkg::*;

	typedef enum logic [10:0] {
		B_IDLE = 11'b00000000001,
		B_MULX = 11'b00000000010,
		B_MULY = 11'b00000000100,
		B_MULD = 11'b00000001000,
		B_NUM  = 11'b00000010000,
		B_DIVP = 11'b00000100000,
		B_DIVS = 11'b00001000000,
		B_QUO  = 11'b00010000000,
		B_SQRT = 11'b00100000000,
		B_FIN  = 11'b01000000000,
		B_OUT  = 11'b10000000000
	} bstate_t;

	bstate_t     state_q;
	logic [27:0] qx_q, qy_q;
	logic [12:0] m_q;
	logic        run_end_q, neg_q, avg_mode_q, sat_q;
	logic [55:0] prod_q;
	logic [56:0] sq_q;
	logic [57:0] rem_q, dsh_q;
	logic [17:0] quo_q;
	logic [4:0]  cnt_q;
	logic [29:0] xs_q;
	logic [30:0] root_q;
	logic [28:0] bit_q;
	logic [15:0] ev_q, evnum_q;
	logic [31:0] acc_q;
	logic [15:0] corr_q;
	logic [14:0] v2_q, avg_q;
	status_t     status_q;
	logic        avgv_q;

	logic        out_valid_q;
	logic [15:0] out_ev_q, out_corr_q;
	logic [12:0] out_tt_q;
	logic [14:0] out_v2_q, out_avg_q;
	logic [1:0]  out_st_q;
	logic        out_avgv_q;

	logic [28:0] cabs, sabs;
	logic [27:0] mul_a, mul_b;
	logic [55:0] mul;
	logic [56:0] m30;
	logic [57:0] dsh_corr;
	logic        rem_ge;
	logic [30:0] sq_sum;
	logic [14:0] v2_nx;
	logic [32:0] acc_sum;
	logic [31:0] acc_nx;
	logic [16:0] neg_val;
	logic [16:0] ev_cnt;
	logic        out_load;

	// magnitudes of the event sums
	assign cabs = rec_in.cos_sum[28] ? $unsigned(29'sd0 - rec_in.cos_sum)
	                                 : $unsigned(rec_in.cos_sum);
	assign sabs = rec_in.sin_sum[28] ? $unsigned(29'sd0 - rec_in.sin_sum)
	                                 : $unsigned(rec_in.sin_sum);

	// shared multiplier
	always_comb begin
		priority if (state_q == B_MULX) begin
			mul_a = qx_q;
			mul_b = qx_q;
		end else if (state_q == B_MULY) begin
			mul_a = qy_q;
			mul_b = qy_q;
		end else begin
			mul_a = {15'b0, m_q};
			mul_b = {15'b0, m_q - 13'd1};
		end
	end
	assign mul = mul_a * mul_b;

	// numerator, divider step, root step
	assign m30      = {14'b0, m_q, 30'b0};
	assign dsh_corr = {prod_q[25:0], 15'b0, 17'b0};
	assign rem_ge   = (rem_q >= dsh_q);
	assign sq_sum   = root_q + {2'b0, bit_q};
	assign v2_nx    = (root_q > 31'd32767) ? 15'h7fff : root_q[14:0];
	assign acc_sum  = {1'b0, acc_q} + {18'b0, v2_nx};
	assign acc_nx   = acc_sum[32] ? 32'hffff_ffff : acc_sum[31:0];
	assign neg_val  = 17'd0 - {1'b0, quo_q[15:0]};
	assign ev_cnt   = {1'b0, ev_q} + 17'd1;

	assign q_pop    = (state_q == B_IDLE) && !q_empty;
	assign out_load = (state_q == B_OUT) && (!out_valid_q || out_ready);

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				qx_q      <= cabs[27:0];
				qy_q      <= sabs[27:0];
				m_q       <= rec_in.m;
				run_end_q <= rec_in.run_end;
				status_q  <= rec_in.cls;
				root_q    <= '0;
				corr_q    <= '0;
				neg_q     <= 1'b0;
			end
			B_MULX: prod_q <= mul;
			B_MULY: begin
				sq_q   <= {1'b0, prod_q};
				prod_q <= mul;
			end
			B_MULD: begin
				sq_q   <= sq_q + {1'b0, prod_q};
				prod_q <= mul;
			end
			B_NUM: begin
				dsh_q <= dsh_corr;
				if (sq_q >= m30) begin
					rem_q <= {1'b0, sq_q - m30};
					neg_q <= 1'b0;
				end else begin
					rem_q <= {1'b0, m30 - sq_q};
					neg_q <= 1'b1;
				end
			end
			B_DIVP: begin
				sat_q <= ({1'b0, rem_q} >= {dsh_q, 1'b0});
				quo_q <= '0;
				cnt_q <= '0;
			end
			B_DIVS: begin
				if (rem_ge) rem_q <= rem_q - dsh_q;
				quo_q <= {quo_q[16:0], rem_ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q + 5'd1;
			end
			B_QUO: begin
				if (avg_mode_q) begin
					avg_q  <= (sat_q || quo_q > 18'd32767) ? 15'h7fff : quo_q[14:0];
					avgv_q <= 1'b1;
				end else if (neg_q) begin
					status_q <= ST_NEG;
					corr_q   <= (quo_q > 18'd32768) ? 16'h8000 : neg_val[15:0];
				end else begin
					corr_q <= (sat_q || quo_q > 18'd32767) ? 16'h7fff : quo_q[15:0];
					xs_q   <= (sat_q || quo_q > 18'd32767) ? {15'h7fff, 15'b0}
					                                       : {quo_q[14:0], 15'b0};
					bit_q  <= 29'h1000_0000;
					cnt_q  <= '0;
				end
			end
			B_SQRT: begin
				if ({1'b0, xs_q} >= sq_sum) begin
					xs_q   <= xs_q - sq_sum[29:0];
					root_q <= (root_q >> 1) + {2'b0, bit_q};
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
			end
			B_FIN: begin
				v2_q    <= v2_nx;
				evnum_q <= ev_q;
				avg_q   <= '0;
				avgv_q  <= 1'b0;
				rem_q   <= {26'b0, acc_nx};
				dsh_q   <= {24'b0, ev_cnt, 17'b0};
			end
			default: ;
		endcase
	end

	// sequencer, run state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			avg_mode_q  <= 1'b0;
			ev_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						avg_mode_q <= 1'b0;
						state_q    <= (rec_in.cls == ST_OK) ? B_MULX : B_FIN;
					end
				end
				B_MULX: state_q <= B_MULY;
				B_MULY: state_q <= B_MULD;
				B_MULD: state_q <= B_NUM;
				B_NUM:  state_q <= B_DIVP;
				B_DIVP: state_q <= B_DIVS;
				B_DIVS: if (cnt_q == 5'd17) state_q <= B_QUO;
				B_QUO: begin
					if (avg_mode_q) begin
						ev_q    <= '0;
						acc_q   <= '0;
						state_q <= B_OUT;
					end else if (neg_q) begin
						state_q <= B_FIN;
					end else begin
						state_q <= B_SQRT;
					end
				end
				B_SQRT: if (cnt_q == 5'd14) state_q <= B_FIN;
				B_FIN: begin
					acc_q <= acc_nx;
					ev_q  <= ev_cnt[15:0];
					if (run_end_q) begin
						avg_mode_q <= 1'b1;
						state_q    <= B_DIVP;
					end else begin
						state_q <= B_OUT;
					end
				end
				B_OUT: if (out_load) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ev_q   <= evnum_q;
			out_tt_q   <= (m_q > MAX_CNT) ? MAX_CNT : m_q;
			out_corr_q <= corr_q;
			out_v2_q   <= v2_q;
			out_st_q   <= status_q;
			out_avg_q  <= avg_q;
			out_avgv_q <= avgv_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_number  = out_ev_q;
	assign track_total   = out_tt_q;
	assign correlation   = out_corr_q;
	assign flow_v2       = out_v2_q;
	assign status        = out_st_q;
	assign run_average   = out_avg_q;
	assign average_valid = out_avgv_q;

endmodule
